[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers for the pixel stream decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge outside reset.
`define BMPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BMPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BMPD_ASSERT(lbl, clk, rst_n, prop, msg)

`define BMPD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[hw/rtl/bmpd_pkg.sv]
`default_nettype none

package bmpd_pkg;

    localparam int MAX_WIDTH       = 4096;
    localparam int HEIGHT_LIMIT    = 4096;
    localparam int PALETTE_ENTRIES = 256;

    localparam int DIM_W     = 13;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WEFF_W    = COL_W + 1;
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int HEFF_W    = ROW_W + 1;
    localparam int PAL_IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CFG_IDX_W = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic FMT_BGR24   = 1'b0;
    localparam logic FMT_PAL8    = 1'b1;
    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PAL_WR  = 1'b1;

    typedef enum logic [1:0] {
        OP_PIXEL     = 2'd0,
        OP_LOOKUP    = 2'd1,
        OP_PAL_WRITE = 2'd2
    } op_kind_t;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2
    } phase_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [PAL_IDX_W-1:0]   index;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic                   last_row;
        logic                   last_img;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bmpd_front.sv]
`default_nettype none

module bmpd_front
    import bmpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 accept,
    input  wire logic                 cmd,
    input  wire logic [7:0]           data_byte,
    input  wire logic [7:0]           pal_index,
    input  wire logic [7:0]           pal_red,
    input  wire logic [7:0]           pal_green,
    input  wire logic [7:0]           pal_blue,
    output logic                      push,
    output op_t                       op
);

    logic             format_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    logic [COL_W-1:0] col_reg,    col_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    phase_t           phase_reg,  phase_next;
    logic [15:0]      held_reg,   held_next;
    logic [1:0]       pad_reg,    pad_next;

    logic [WEFF_W-1:0] w_eff;
    logic [HEFF_W-1:0] h_eff;
    logic [1:0]        row_bytes_lo;
    logic              end_row;
    logic              end_img;
    logic              do_emit;
    logic              take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_BGR24;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: format_reg <= cfg_data[0];
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          format_reg <= format_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WEFF_W'(1);
        else if (width_reg > MAX_WIDTH)
            w_eff = WEFF_W'(MAX_WIDTH);
        else
            w_eff = WEFF_W'(width_reg);

        if (height_reg == '0)
            h_eff = HEFF_W'(1);
        else if (height_reg > HEIGHT_LIMIT)
            h_eff = HEFF_W'(HEIGHT_LIMIT);
        else
            h_eff = HEFF_W'(height_reg);

        row_bytes_lo = (format_reg == FMT_PAL8) ? w_eff[1:0] : 2'(w_eff[1:0] * 2'd3);
        end_row = ({1'b0, col_reg} + WEFF_W'(1)) >= w_eff;
        end_img = ({1'b0, row_reg} + HEFF_W'(1)) >= h_eff;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        pad_next   = pad_reg;
        push       = 1'b0;
        do_emit    = 1'b0;
        take       = accept;

        op.kind     = OP_PIXEL;
        op.index    = data_byte[PAL_IDX_W-1:0];
        op.red      = data_byte;
        op.green    = held_reg[15:8];
        op.blue     = held_reg[7:0];
        op.last_row = 1'b0;
        op.last_img = 1'b0;

        priority if (!take)
        begin
            push = 1'b0;
        end
        else if (cmd == CMD_PAL_WR)
        begin
            op.kind  = OP_PAL_WRITE;
            op.index = pal_index[PAL_IDX_W-1:0];
            op.red   = pal_red;
            op.green = pal_green;
            op.blue  = pal_blue;
            push     = ({1'b0, pal_index} < 9'(PALETTE_ENTRIES));
        end
        else if (pad_reg != 2'd0)
        begin
            pad_next = pad_reg - 2'd1;
        end
        else if (format_reg == FMT_PAL8)
        begin
            do_emit = 1'b1;
            if ({1'b0, data_byte} < 9'(PALETTE_ENTRIES))
                op.kind = OP_LOOKUP;
            else
            begin
                op.red   = 8'd0;
                op.green = 8'd0;
                op.blue  = 8'd0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_BLUE:
                begin
                    held_next  = {held_reg[15:8], data_byte};
                    phase_next = PH_GREEN;
                end
                PH_GREEN:
                begin
                    held_next  = {data_byte, held_reg[7:0]};
                    phase_next = PH_RED;
                end
                default:
                begin
                    phase_next = PH_BLUE;
                    do_emit    = 1'b1;
                end
            endcase
        end

        if (do_emit)
        begin
            push        = 1'b1;
            op.last_row = end_row;
            op.last_img = end_row & end_img;
            if (end_row)
            begin
                col_next = '0;
                pad_next = 2'd0 - row_bytes_lo;
                row_next = end_img ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= PH_BLUE;
            held_reg  <= '0;
            pad_reg   <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            pad_reg   <= pad_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bmpd_queue.sv]
`default_nettype none

module bmpd_queue
    import bmpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    input  wire logic pop,
    output op_t       head_op,
    output q_stat_t   stat
);

    op_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
        stat.empty  = (count_reg == '0);
        stat.full   = (count_reg == Q_CNT_W'(Q_DEPTH));
        head_op     = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bmpd_back.sv]
`default_nettype none

module bmpd_back
    import bmpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_stat_t q_stat,
    input  wire op_t     head_op,
    output logic         pop,
    output logic         pixel_valid,
    input  wire logic    pixel_stall,
    output logic [7:0]   red,
    output logic [7:0]   green,
    output logic [7:0]   blue,
    output logic         last_in_row,
    output logic         last_in_image
);

    logic [23:0] pal_mem [PALETTE_ENTRIES];

    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [23:0] rd_data_reg;
    logic        out_valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        last_row_reg, last_img_reg;

    logic        out_free;
    logic        s1_move;
    logic        s1_free;
    logic        is_write;
    logic        s1_load;
    logic [23:0] s1_rgb;

    always_comb
    begin
        out_free = !out_valid_reg || !pixel_stall;
        s1_move  = s1_valid_reg && out_free;
        s1_free  = !s1_valid_reg || s1_move;
        is_write = (head_op.kind == OP_PAL_WRITE);
        pop      = !q_stat.empty && (is_write || s1_free);
        s1_load  = pop && !is_write;
        s1_rgb   = (s1_op_reg.kind == OP_LOOKUP) ? rd_data_reg
                 : {s1_op_reg.red, s1_op_reg.green, s1_op_reg.blue};
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_write)
            pal_mem[head_op.index] <= {head_op.red, head_op.green, head_op.blue};
        if (s1_load)
        begin
            rd_data_reg <= pal_mem[head_op.index];
            s1_op_reg   <= head_op;
        end
        if (s1_move)
        begin
            red_reg      <= s1_rgb[23:16];
            green_reg    <= s1_rgb[15:8];
            blue_reg     <= s1_rgb[7:0];
            last_row_reg <= s1_op_reg.last_row;
            last_img_reg <= s1_op_reg.last_img;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= s1_load;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign pixel_valid   = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign last_in_row   = last_row_reg;
    assign last_in_image = last_img_reg;

endmodule

`default_nettype wire

[hw/rtl/bmp_pixel_stream_decoder.sv]
// Channel   Handshake                 Payload
// byte      byte_valid / byte_stall   cmd, data_byte, pal_index, pal_red, pal_green, pal_blue
// pixel     pixel_valid / pixel_stall red, green, blue, last_in_row, last_in_image
// config    cfg_we                    cfg_index, cfg_data
//
// One byte request is taken per cycle while byte_stall is low; a pixel's final byte
// passes the four-entry queue, the registered palette read and the output register.
// Reset is asynchronous, active low: counters, phase and pad clear, the palette does not.
// byte_stall rises only when the queue between front and back is full.
// A pixel_stall holds the output register; the queue absorbs bytes meanwhile.
`default_nettype none

`include "assert_macros.svh"

module bmp_pixel_stream_decoder
    import bmpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    input  wire logic                 cmd,
    input  wire logic [7:0]           data_byte,
    input  wire logic [7:0]           pal_index,
    input  wire logic [7:0]           pal_red,
    input  wire logic [7:0]           pal_green,
    input  wire logic [7:0]           pal_blue,
    output logic                      pixel_valid,
    input  wire logic                 pixel_stall,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic                      last_in_row,
    output logic                      last_in_image
);

    logic    accept;
    logic    q_push;
    logic    q_pop;
    op_t     push_op;
    op_t     head_op;
    q_stat_t q_stat;

    assign byte_stall = q_stat.full;
    assign accept     = byte_valid && !byte_stall;

    bmpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (cmd),
        .data_byte (data_byte),
        .pal_index (pal_index),
        .pal_red   (pal_red),
        .pal_green (pal_green),
        .pal_blue  (pal_blue),
        .push      (q_push),
        .op        (push_op)
    );

    bmpd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .stat    (q_stat)
    );

    bmpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head_op       (head_op),
        .pop           (q_pop),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last_in_row   (last_in_row),
        .last_in_image (last_in_image)
    );

    `BMPD_ASSERT(a_no_push_when_full, clk, rst_n, q_push |-> !q_stat.full, "push into full queue")
    `BMPD_ASSERT(a_no_pop_when_empty, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty queue")
    `BMPD_ASSERT(a_image_end_is_row_end, clk, rst_n, (pixel_valid && last_in_image) |-> last_in_row, "image end without row end")
    `BMPD_ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |-> !pixel_valid, "pixel during reset")

endmodule

`default_nettype wire

[test/tb_bmp_pixel_stream_decoder.sv]
`timescale 1ns / 1ps

module tb_bmp_pixel_stream_decoder;
    import bmpd_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       image_end;
    } pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 byte_valid;
    logic                 byte_stall;
    logic                 cmd;
    logic [7:0]           data_byte;
    logic [7:0]           pal_index;
    logic [7:0]           pal_red;
    logic [7:0]           pal_green;
    logic [7:0]           pal_blue;
    logic                 pixel_valid;
    logic                 pixel_stall;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 last_in_row;
    logic                 last_in_image;

    // decoder state as seen from the byte stream
    logic [23:0]      palette_mem [PALETTE_ENTRIES];
    bit               palette_written [PALETTE_ENTRIES];
    int               col_cnt;
    int               row_cnt;
    int               pad_left;
    phase_t           byte_phase;
    logic [15:0]      held_bg;
    logic             fmt;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    pixel_t expected_pixels[$];
    int     mismatches;
    int     sent_items;
    int     seen_pixels;
    int     stall_left;
    bit     tx_calm;
    bit     rx_calm;

    bmp_pixel_stream_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .pal_index     (pal_index),
        .pal_red       (pal_red),
        .pal_green     (pal_green),
        .pal_blue      (pal_blue),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last_in_row   (last_in_row),
        .last_in_image (last_in_image)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("bmp_pixel_stream_decoder verification failed");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dimension(input int small_max);
        if ($urandom_range(0, 9) != 0)
            return DIM_W'($urandom_range(1, small_max));
        case ($urandom_range(0, 3))
            0: return '0;
            1: return DIM_W'(MAX_WIDTH);
            2: return '1;
            default: return DIM_W'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic void decode_request(input logic c, input logic [7:0] d,
                                           input logic [7:0] pi, input logic [7:0] pr,
                                           input logic [7:0] pg, input logic [7:0] pb);
        int     w;
        int     h;
        int     row_bytes;
        pixel_t px;
        px = '0;
        if (c == CMD_PAL_WR)
        begin
            palette_mem[pi] = {pr, pg, pb};
            palette_written[pi] = 1'b1;
            return;
        end
        if (pad_left != 0)
        begin
            pad_left--;
            return;
        end
        if (fmt == FMT_PAL8)
        begin
            {px.red, px.green, px.blue} = palette_mem[d];
        end
        else if (byte_phase == PH_BLUE)
        begin
            held_bg[7:0] = d;
            byte_phase = PH_GREEN;
            return;
        end
        else if (byte_phase == PH_GREEN)
        begin
            held_bg[15:8] = d;
            byte_phase = PH_RED;
            return;
        end
        else
        begin
            byte_phase = PH_BLUE;
            px.red = d;
            px.green = held_bg[15:8];
            px.blue = held_bg[7:0];
        end
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h = (height_reg == 0) ? 1 :
            ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg));
        if (col_cnt + 1 >= w)
        begin
            row_bytes = (fmt == FMT_PAL8) ? w : 3 * w;
            px.row_end = 1'b1;
            col_cnt = 0;
            pad_left = (4 - row_bytes % 4) % 4;
            if (row_cnt + 1 >= h)
            begin
                px.image_end = 1'b1;
                row_cnt = 0;
            end
            else
            begin
                row_cnt++;
            end
        end
        else
        begin
            col_cnt++;
        end
        expected_pixels.push_back(px);
    endfunction

    task automatic send_request(input logic c, input logic [7:0] d, input logic [7:0] pi,
                                input logic [7:0] pr, input logic [7:0] pg,
                                input logic [7:0] pb);
        int gap;
        if (sent_items % 40 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        cmd        <= c;
        data_byte  <= d;
        pal_index  <= pi;
        pal_red    <= pr;
        pal_green  <= pg;
        pal_blue   <= pb;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        decode_request(c, d, pi, pr, pg, pb);
        sent_items++;
    endtask

    task automatic send_pixel_byte(input logic [7:0] d);
        // load the entry first so that no lookup hits an unwritten one
        if (fmt == FMT_PAL8 && pad_left == 0 && !palette_written[d])
            send_request(CMD_PAL_WR, rand_byte(), d, rand_byte(), rand_byte(), rand_byte());
        send_request(CMD_PIXEL, d, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic settle();
        byte_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DIM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_PIXEL_FORMAT: fmt = value[0];
            REG_IMAGE_WIDTH:  width_reg = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic f, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h);
        settle();
        write_register(REG_PIXEL_FORMAT, DIM_W'(f));
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    task automatic change_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [DIM_W-1:0] value);
        settle();
        write_register(idx, value);
        cfg_we <= 1'b0;
    endtask

    task automatic test_bgr24_defaults();
        repeat (3) send_pixel_byte(8'h00);
        send_pixel_byte(8'hFF);
        repeat (3) send_pixel_byte(8'hFF);
        send_request(CMD_PAL_WR, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_pixel_byte(8'h00);
    endtask

    task automatic test_palette_lookup();
        configure(FMT_PAL8, 13'd2, 13'd2);
        send_request(CMD_PAL_WR, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hFF);
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hFF);
        send_pixel_byte(8'hFF);
        send_pixel_byte(8'h00);
    endtask

    task automatic test_dimension_limits();
        configure(FMT_BGR24, 13'd0, 13'd0);
        repeat (5) send_pixel_byte(rand_byte());
        configure(FMT_PAL8, 13'h1FFF, 13'h1FFF);
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hFF);
        send_pixel_byte(8'h00);
    endtask

    task automatic test_mid_pixel_changes();
        configure(FMT_BGR24, 13'd3, 13'd2);
        send_pixel_byte(8'h12);
        change_register(REG_PIXEL_FORMAT, DIM_W'(FMT_PAL8));
        send_pixel_byte(8'hFF);
        send_pixel_byte(8'h00);
        change_register(REG_PIXEL_FORMAT, DIM_W'(FMT_BGR24));
        send_pixel_byte(8'h34);
        send_pixel_byte(8'h56);
        change_register(REG_IMAGE_WIDTH, 13'd1);
        repeat (3) send_pixel_byte(rand_byte());
    endtask

    task automatic test_random_streams();
        int                   first;
        int                   n;
        logic [CFG_IDX_W-1:0] idx;
        first = sent_items;
        while (sent_items - first < 550)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                idx = CFG_IDX_W'($urandom_range(0, 2));
                change_register(idx, (idx == REG_PIXEL_FORMAT) ?
                                DIM_W'($urandom_range(0, 1)) : pick_dimension(6));
            end
            else
            begin
                configure(1'($urandom_range(0, 1)), pick_dimension(9), pick_dimension(4));
            end
            n = $urandom_range(8, 48);
            repeat (n)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(CMD_PAL_WR, rand_byte(), rand_byte(), rand_byte(),
                                 rand_byte(), rand_byte());
                else
                    send_pixel_byte(rand_byte());
            end
        end
    endtask

    always @(posedge clk)
    begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                got = {red, green, blue, last_in_row, last_in_image};
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected pixel r=%02h g=%02h b=%02h row=%0b img=%0b",
                                 got.red, got.green, got.blue, got.row_end, got.image_end);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.row_end !== want.row_end ||
                        got.image_end !== want.image_end)
                    begin
                        if (mismatches < 10)
                            $display({"pixel mismatch: expected r=%02h g=%02h b=%02h ",
                                      "row=%0b img=%0b, got r=%02h g=%02h b=%02h ",
                                      "row=%0b img=%0b"},
                                     want.red, want.green, want.blue, want.row_end,
                                     want.image_end, got.red, got.green, got.blue,
                                     got.row_end, got.image_end);
                        mismatches++;
                    end
                end
                seen_pixels++;
                if (seen_pixels % 32 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                stall_left = rx_calm ? 0 : $urandom_range(0, 10);
            end
            pixel_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_PIXEL_FORMAT;
        cfg_data    = '0;
        byte_valid  = 1'b0;
        cmd         = CMD_PIXEL;
        data_byte   = '0;
        pal_index   = '0;
        pal_red     = '0;
        pal_green   = '0;
        pal_blue    = '0;
        pixel_stall = 1'b0;
        col_cnt     = 0;
        row_cnt     = 0;
        pad_left    = 0;
        byte_phase  = PH_BLUE;
        held_bg     = '0;
        fmt         = FMT_BGR24;
        width_reg   = 13'd1;
        height_reg  = 13'd1;
        mismatches  = 0;
        sent_items  = 0;
        seen_pixels = 0;
        stall_left  = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bgr24_defaults();
        test_palette_lookup();
        test_dimension_limits();
        test_mid_pixel_changes();
        test_random_streams();
        settle();
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("bmp_pixel_stream_decoder verification clean");
        else
            $display("bmp_pixel_stream_decoder verification failed");
        $finish;
    end

endmodule
